/* design/lhp_pkg.sv */
// Shared types and constants for the latency histogram block.
package lhp_pkg;

   localparam int ACTION_W  = 2;
   localparam int ELAPSED_W = 64;
   localparam int DATA_W    = 32;
   localparam int PCT_W     = 7;
   localparam int SUM_W     = 64;
   localparam int TARGET_W  = DATA_W + PCT_W;

   localparam logic [ACTION_W-1:0] ACT_RECORD = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

   localparam logic [PCT_W-1:0] PCT_RESET = 7'd95;
   localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

   // divider handshake back to the controller
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* design/lhp_ifs.sv */
// Channel interfaces: request, response and control register write.
interface lhp_req_if import lhp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  action;
   logic [ELAPSED_W-1:0] elapsed_us;

   modport source (output valid, action, elapsed_us, input ready);
   modport sink   (input valid, action, elapsed_us, output ready);
endinterface

interface lhp_rsp_if import lhp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] sample_count;
   logic [DATA_W-1:0] mean_us;
   logic [DATA_W-1:0] percentile_us;
   logic [DATA_W-1:0] max_us;

   modport source (output valid, sample_count, mean_us, percentile_us, max_us, input ready);
   modport sink   (input valid, sample_count, mean_us, percentile_us, max_us, output ready);
endinterface

interface lhp_csr_if import lhp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PCT_W-1:0] percentile_pct;

   modport source (output valid, percentile_pct, input ready);
   modport sink   (input valid, percentile_pct, output ready);
endinterface

/* design/lhp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module lhp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 401
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/lhp_div.sv */
// Restoring divider, one quotient bit per cycle, for the mean.
module lhp_div import lhp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SUM_W-1:0]     dividend,
   input  logic [DATA_W-1:0]    divisor,
   output div_status_type       status,
   output logic [SUM_W-1:0]     quotient
);

   localparam int STEP_W = $clog2(SUM_W);

   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DATA_W:0]   rem_sh;
   logic [DATA_W+1:0] trial;
   logic              ge;

   assign rem_sh = {rem_ff, quo_ff[SUM_W-1]};
   assign trial  = {1'b0, rem_sh} - {2'b00, divisor};
   assign ge     = !trial[DATA_W+1];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         step_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in  = ge ? trial[DATA_W-1:0] : rem_sh[DATA_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

/* design/latency_histogram_percentile_top.sv */
// Latency histogram top level: sample recording, percentile scan and statistics report.
// Each request transaction carries an action. A record transaction saturates
// elapsed_us to 32 bits, updates sum, count and maximum at once and bumps one
// histogram bin (BIN_WIDTH_US wide, bin OVERFLOW_BIN catches the rest) by a
// read-modify-write of the bin RAM; it occupies the block through accept,
// bin index multiply, RAM read and RAM write. A query transaction starts a
// restoring divider for the mean and streams every bin out of the RAM, one
// per cycle, through a 3-stage accumulate/compare pipe; its response
// transaction is loaded once the scan and the divider are both done and the
// response register has drained. A clear transaction, and reset itself,
// sweep the RAM writing zero one bin per cycle, with req_ch.ready low for
// the whole sweep. Unused action code 3 is accepted and dropped. A finished
// response sits in an output register, so new record and clear transactions
// are taken while it waits. The percentile register can be written any time
// the block is idle; csr_ch.ready is always high.
module latency_histogram_percentile_top import lhp_pkg::*; #(
   parameter int unsigned OVERFLOW_BIN = 400,
   parameter int unsigned BIN_WIDTH_US = 50
) (
   input logic        clock,
   input logic        reset,
   lhp_req_if.sink    req_ch,
   lhp_rsp_if.source  rsp_ch,
   lhp_csr_if.sink    csr_ch
);

   localparam int unsigned NUM_BINS = OVERFLOW_BIN + 1;
   localparam int          AW       = $clog2(NUM_BINS);
   localparam int          CUM_W    = TARGET_W + AW;

   // bin index = us / BIN_WIDTH_US by reciprocal multiply, exact for us < THRESH
   localparam longint unsigned THRESH = longint'(OVERFLOW_BIN) * BIN_WIDTH_US;
   localparam int              QN     = $clog2(THRESH + 1);
   localparam int              SHIFT  = QN + $clog2(BIN_WIDTH_US);
   localparam int              RW     = QN + 2;
   localparam int              PW     = QN + RW;
   localparam longint unsigned RECIP  =
      ((64'd1 << SHIFT) + BIN_WIDTH_US - 1) / BIN_WIDTH_US;

   localparam logic [RW-1:0]     RECIP_V   = RECIP[RW-1:0];
   localparam logic [DATA_W-1:0] THRESH_V  = THRESH[DATA_W-1:0];
   localparam logic [DATA_W-1:0] BIN_W_V   = DATA_W'(BIN_WIDTH_US);
   localparam logic [DATA_W-1:0] EDGE_NONE = DATA_W'(longint'(NUM_BINS) * BIN_WIDTH_US);
   localparam logic [AW-1:0]     LAST_BIN  = AW'(OVERFLOW_BIN);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REC_MUL,
      ST_REC_RD,
      ST_REC_WR,
      ST_QUERY
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [PCT_W-1:0] pct_ff, pct_in;

   // running statistics
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [DATA_W-1:0] count_ff, count_in;
   logic [DATA_W-1:0] max_ff, max_in;

   // record path
   logic [DATA_W-1:0] us_ff;
   logic [PW-1:0]     rprod_ff;
   logic              ovf_ff;
   logic [PW-1:0]     rquot;
   logic [AW-1:0]     bin_ff, bin_in;

   // clear sweep
   logic [AW-1:0] clr_idx_ff;

   // query scan pipeline
   logic [AW-1:0]       scan_idx_ff;
   logic                issue_done_ff;
   logic                v1_ff, v2_ff, v3_ff;
   logic [AW-1:0]       idx1_ff, idx2_ff, idx3_ff;
   logic [TARGET_W-1:0] prod2_ff;
   logic [CUM_W-1:0]    cum_ff;
   logic [TARGET_W-1:0] target_ff;
   logic                hit_ff;
   logic [AW-1:0]       hit_idx_ff;
   logic                scan_done;

   // divider
   logic           div_start;
   div_status_type div_stat;
   logic [SUM_W-1:0] div_quo;

   // bin RAM ports
   logic              ram_wr_en, ram_rd_en;
   logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
   logic [DATA_W-1:0] ram_wr_data, ram_rd_data;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_count_ff, rsp_count_in;
   logic [DATA_W-1:0] rsp_mean_ff, rsp_mean_in;
   logic [DATA_W-1:0] rsp_pctl_ff, rsp_pctl_in;
   logic [DATA_W-1:0] rsp_max_ff, rsp_max_in;

   logic              req_fire;
   logic              rsp_load;
   logic [DATA_W-1:0] sat_us;
   logic [DATA_W-1:0] mean_val;
   logic [DATA_W-1:0] edge_val;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // saturate the measured duration to 32 bits
   assign sat_us = (|req_ch.elapsed_us[ELAPSED_W-1:DATA_W]) ? '1
                                                             : req_ch.elapsed_us[DATA_W-1:0];

   //-----------------------------------------------------------------------
   // Percentile register
   //-----------------------------------------------------------------------
   always_comb begin
      pct_in = pct_ff;
      if (csr_ch.valid) begin
         pct_in = csr_ch.percentile_pct;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pct_ff <= PCT_RESET;
      end else begin
         pct_ff <= pct_in;
      end
   end

   //-----------------------------------------------------------------------
   // Sum, count and maximum update on accept
   //-----------------------------------------------------------------------
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      max_in   = max_ff;
      if (req_fire) begin
         unique case (req_ch.action)
            ACT_RECORD: begin
               sum_in   = sum_ff + {{(SUM_W-DATA_W){1'b0}}, sat_us};
               count_in = count_ff + 1'b1;
               if (sat_us > max_ff) begin
                  max_in = sat_us;
               end
            end
            ACT_CLEAR: begin
               sum_in   = '0;
               count_in = '0;
               max_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         max_ff   <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         max_ff   <= max_in;
      end
   end

   //-----------------------------------------------------------------------
   // Record path: bin index via reciprocal multiply, then RAM read-modify-write
   //-----------------------------------------------------------------------
   assign rquot  = rprod_ff >> SHIFT;
   assign bin_in = ovf_ff ? LAST_BIN : rquot[AW-1:0];

   always_ff @(posedge clock) begin
      if (req_fire) begin
         us_ff <= sat_us;
      end
      if (state_ff == ST_REC_MUL) begin
         ovf_ff   <= (us_ff >= THRESH_V);
         rprod_ff <= {{RW{1'b0}}, us_ff[QN-1:0]} * {{QN{1'b0}}, RECIP_V};
      end
      if (state_ff == ST_REC_RD) begin
         bin_ff <= bin_in;
      end
   end

   //-----------------------------------------------------------------------
   // Query: scan pipeline over the bins
   //   issue read -> data*100 -> accumulate -> compare with count*pct
   //-----------------------------------------------------------------------
   assign div_start = req_fire && (req_ch.action == ACT_QUERY);
   assign scan_done = issue_done_ff && !v1_ff && !v2_ff && !v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_done_ff <= 1'b1;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         hit_ff        <= 1'b0;
      end else if (div_start) begin
         issue_done_ff <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         hit_ff        <= 1'b0;
      end else begin
         v1_ff <= (state_ff == ST_QUERY) && !issue_done_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if ((state_ff == ST_QUERY) && !issue_done_ff && (scan_idx_ff == LAST_BIN)) begin
            issue_done_ff <= 1'b1;
         end
         if (v3_ff && !hit_ff && (cum_ff >= {{AW{1'b0}}, target_ff})) begin
            hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         scan_idx_ff <= '0;
         cum_ff      <= '0;
         target_ff   <= {{PCT_W{1'b0}}, count_ff} * {{DATA_W{1'b0}}, pct_ff};
      end else begin
         if ((state_ff == ST_QUERY) && !issue_done_ff && (scan_idx_ff != LAST_BIN)) begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
         if (v2_ff) begin
            cum_ff <= cum_ff + {{AW{1'b0}}, prod2_ff};
         end
      end
      idx1_ff  <= scan_idx_ff;
      idx2_ff  <= idx1_ff;
      idx3_ff  <= idx2_ff;
      prod2_ff <= {{PCT_W{1'b0}}, ram_rd_data} * {{DATA_W{1'b0}}, PCT_SCALE};
      if (v3_ff && !hit_ff) begin
         hit_idx_ff <= idx3_ff;
      end
   end

   //-----------------------------------------------------------------------
   // Clear sweep index
   //-----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (req_fire && (req_ch.action == ACT_CLEAR)) begin
         clr_idx_ff <= '0;
      end else if ((state_ff == ST_CLEAR) && (clr_idx_ff != LAST_BIN)) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
      end
   end

   //-----------------------------------------------------------------------
   // Bin RAM access
   //-----------------------------------------------------------------------
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = clr_idx_ff;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = scan_idx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
         end
         ST_REC_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = bin_in;
         end
         ST_REC_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = bin_ff;
            ram_wr_data = ram_rd_data + 1'b1;
         end
         ST_QUERY: begin
            ram_rd_en = !issue_done_ff;
         end
         default: begin
         end
      endcase
   end

   lhp_ram #(
      .WIDTH (DATA_W),
      .DEPTH (NUM_BINS)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lhp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .status   (div_stat),
      .quotient (div_quo)
   );

   //-----------------------------------------------------------------------
   // Result values
   //-----------------------------------------------------------------------
   always_comb begin
      if (count_ff == '0) begin
         mean_val = '0;
      end else if (|div_quo[SUM_W-1:DATA_W]) begin
         mean_val = '1;
      end else begin
         mean_val = div_quo[DATA_W-1:0];
      end
   end

   always_comb begin
      priority if (!hit_ff) begin
         edge_val = EDGE_NONE;          // target never reached
      end else if (hit_idx_ff == LAST_BIN) begin
         edge_val = max_ff;             // overflow bin reports the maximum
      end else begin
         edge_val = (DATA_W'(hit_idx_ff) + 1'b1) * BIN_W_V;
      end
   end

   assign rsp_load = (state_ff == ST_QUERY) && scan_done && div_stat.done &&
                     (!rsp_valid_ff || rsp_ch.ready);

   //-----------------------------------------------------------------------
   // Controller and response register
   //-----------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_pctl_in  = rsp_pctl_ff;
      rsp_max_in   = rsp_max_ff;

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_idx_ff == LAST_BIN) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_ch.action)
                  ACT_RECORD: state_in = ST_REC_MUL;
                  ACT_QUERY:  state_in = ST_QUERY;
                  ACT_CLEAR:  state_in = ST_CLEAR;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_REC_MUL: state_in = ST_REC_RD;
         ST_REC_RD:  state_in = ST_REC_WR;
         ST_REC_WR:  state_in = ST_IDLE;
         ST_QUERY: begin
            if (rsp_load) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               rsp_mean_in  = mean_val;
               rsp_pctl_in  = edge_val;
               rsp_max_in   = max_ff;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_count_ff <= rsp_count_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_pctl_ff  <= rsp_pctl_in;
      rsp_max_ff   <= rsp_max_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.sample_count  = rsp_count_ff;
   assign rsp_ch.mean_us       = rsp_mean_ff;
   assign rsp_ch.percentile_us = rsp_pctl_ff;
   assign rsp_ch.max_us        = rsp_max_ff;

endmodule

/* design/lhp_checker.sv */
// Port-level assertions for the latency histogram block, bound to the top level.
module lhp_checker import lhp_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_sample_count,
   input logic [DATA_W-1:0] rsp_mean_us,
   input logic [DATA_W-1:0] rsp_percentile_us,
   input logic [DATA_W-1:0] rsp_max_us
);

   // reset starts the bin sweep, so no request is taken right after it
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted during post-reset bin sweep");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_empty_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_sample_count == '0) |-> (rsp_mean_us == '0))
      else $error("nonzero mean reported with no samples");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_count) &&
         $stable(rsp_mean_us) && $stable(rsp_percentile_us) && $stable(rsp_max_us))
      else $error("stalled response transaction changed");

endmodule

bind latency_histogram_percentile_top lhp_checker u_lhp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_sample_count  (rsp_ch.sample_count),
   .rsp_mean_us       (rsp_ch.mean_us),
   .rsp_percentile_us (rsp_ch.percentile_us),
   .rsp_max_us        (rsp_ch.max_us)
);
